[rtl/dfw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfw_pkg
// Shared types and constants for the DDS tuning word serial writer.
// ----------------------------------------------------------------------------
package dfw_pkg;

    // Word and register widths.
    localparam int WORD_BITS = 28;
    localparam int HALF_BITS = WORD_BITS / 2;
    localparam int CLK_BITS  = 27;
    localparam int FREQ_BITS = 32;
    localparam int NUM_BITS  = 60;
    localparam int REM_BITS  = 36;

    localparam logic [WORD_BITS-1:0] WORD_MAX     = '1;
    localparam logic [CLK_BITS-1:0]  CLK_HZ_RESET = 27'd25000000;

    // Request type codes.
    localparam logic [1:0] REQ_INIT = 2'd0;
    localparam logic [1:0] REQ_HZ   = 2'd1;
    localparam logic [1:0] REQ_RAW  = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    // Command frames.
    localparam int          FRAME_BITS  = 16;
    localparam int          RUN_BITS    = 2 * FRAME_BITS;
    localparam logic [15:0] FRAME_RESET = 16'h0100;
    localparam logic [15:0] FRAME_B28   = 16'h2000;
    localparam logic [15:0] CMD_FREQ0   = 16'h4000;

    // One input request.
    typedef struct packed {
        logic [1:0]                  req_type;
        logic signed [FREQ_BITS-1:0] freq_q8;
        logic [WORD_BITS-1:0]        tuning_word;
    } t_in;

    // One serial output bit.
    typedef struct packed {
        logic mosi_bit;
        logic frame_end;
        logic last;
    } t_out;

    // Decoded request handed to the divider.
    typedef struct packed {
        logic [1:0]           kind;
        logic                 neg;
        logic [NUM_BITS-1:0]  num;
        logic [WORD_BITS-1:0] raw;
    } t_div_req;

    // Finished job handed to the serializer.
    typedef struct packed {
        logic                 is_init;
        logic [WORD_BITS-1:0] word;
    } t_job;

endpackage
`default_nettype wire

[rtl/dfw_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfw_div
// Restoring divider that turns a scaled frequency into a saturated tuning
// word, one quotient bit per cycle. Other requests go straight to the done state.
// ----------------------------------------------------------------------------
module dfw_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire dfw_pkg::t_div_req             i_req,
    input  wire logic [dfw_pkg::CLK_BITS-1:0]  i_clk_hz,
    output logic                               o_valid,
    output dfw_pkg::t_job                      o_job,
    input  wire logic                          i_take
);
    import dfw_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [4:0]           r_cnt, n_cnt;
    logic [REM_BITS-1:0]  r_rem, n_rem;
    logic [WORD_BITS-1:0] r_low, n_low;
    logic [WORD_BITS-1:0] r_quo, n_quo;
    t_job                 r_job, n_job;

    logic [REM_BITS-1:0]  den;
    logic [REM_BITS-1:0]  shifted;
    logic [REM_BITS-1:0]  diff;
    logic                 ge;
    logic                 load;

    // Divisor is the master clock times 256.
    assign den = {1'b0, i_clk_hz, 8'h00};

    // The first step only checks for overflow; later steps bring in a bit.
    assign shifted = (r_cnt == 5'd0) ? r_rem : {r_rem[REM_BITS-2:0], r_low[WORD_BITS-1]};
    assign ge      = (shifted >= den);
    assign diff    = shifted - den;

    assign o_ready = (r_state == ST_IDLE) || ((r_state == ST_DONE) && i_take);
    assign load    = o_ready && i_valid;
    assign o_valid = (r_state == ST_DONE);
    assign o_job   = r_job;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_low   = r_low;
        n_quo   = r_quo;
        n_job   = r_job;
        unique case (r_state)
            ST_BUSY: begin
                if (r_cnt == 5'd0) begin
                    if (ge) begin
                        n_job.word = WORD_MAX;
                        n_state    = ST_DONE;
                    end else begin
                        n_cnt = 5'd1;
                    end
                end else begin
                    n_low = {r_low[WORD_BITS-2:0], 1'b0};
                    n_rem = ge ? diff : shifted;
                    n_quo = {r_quo[WORD_BITS-2:0], ge};
                    if (r_cnt == 5'(WORD_BITS)) begin
                        n_job.word = {r_quo[WORD_BITS-2:0], ge};
                        n_state    = ST_DONE;
                    end else begin
                        n_cnt = r_cnt + 5'd1;
                    end
                end
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A new request is taken when idle or as the finished one leaves.
        if (load) begin
            n_job.is_init = (i_req.kind == REQ_INIT);
            if ((i_req.kind == REQ_HZ) && !i_req.neg) begin
                n_state = ST_BUSY;
                n_cnt   = 5'd0;
                n_rem   = {4'b0, i_req.num[NUM_BITS-1:WORD_BITS]};
                n_low   = i_req.num[WORD_BITS-1:0];
                n_quo   = '0;
            end else begin
                n_job.word = i_req.neg ? '0 : i_req.raw;
                n_state    = ST_DONE;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_low <= n_low;
        r_quo <= n_quo;
        r_job <= n_job;
    end

endmodule
`default_nettype wire

[rtl/dfw_ser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfw_ser
// Builds the two command frames of a job and shifts them out one bit per
// cycle while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module dfw_ser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_take,
    input  wire dfw_pkg::t_job i_job,
    output logic               o_out_valid,
    output dfw_pkg::t_out      o_out,
    input  wire logic          i_out_stall
);
    import dfw_pkg::*;

    logic                r_busy;
    logic [4:0]          r_cnt;
    logic [RUN_BITS-1:0] r_shift;
    logic                r_out_valid;
    t_out                r_out;

    logic                adv;
    logic                run_end;
    logic [RUN_BITS-1:0] frames;

    // A bit moves to the output register whenever that register is free.
    assign adv     = r_busy && (!r_out_valid || !i_out_stall);
    assign run_end = (r_cnt == 5'(RUN_BITS - 1));
    assign o_take  = !r_busy || (adv && run_end);

    // Frames of the next job: two control frames or two FREQ0 writes.
    always_comb begin
        if (i_job.is_init) begin
            frames = {FRAME_RESET, FRAME_B28};
        end else begin
            frames = {CMD_FREQ0 | {2'b00, i_job.word[HALF_BITS-1:0]},
                      CMD_FREQ0 | {2'b00, i_job.word[WORD_BITS-1:HALF_BITS]}};
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_take && i_valid) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (adv) begin
                r_cnt <= r_cnt + 5'd1;
                if (run_end) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Shift register and output payload.
    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_shift <= frames;
        end else if (adv) begin
            r_shift <= {r_shift[RUN_BITS-2:0], 1'b0};
        end
        if (adv) begin
            r_out.mosi_bit  <= r_shift[RUN_BITS-1];
            r_out.frame_end <= (r_cnt[3:0] == 4'hF);
            r_out.last      <= run_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

[rtl/dds_frequency_word_spi_writer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dds_frequency_word_spi_writer
// Turns init, raw-word and frequency requests into serial DDS command frames.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      i_in_valid / o_in_stall    i_in  (t_in)
//   out       output     o_out_valid / i_out_stall  o_out (t_out, one bit)
//   cfg       input      i_cfg_wr_en                i_cfg_wr_data (master clock)
//
// Every request of a known type gives 32 output bits, one per cycle while
// the output is not stalled, so the sustained rate is set by the bit
// serializer. A frequency request is divided while the previous request's
// bits are still shifting out.
// Reset is synchronous and needs no clearing pass. Stalls on the output hold
// the output register and back up through the serializer, divider and input.
// ----------------------------------------------------------------------------
module dds_frequency_word_spi_writer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire dfw_pkg::t_in                  i_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output dfw_pkg::t_out                      o_out,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [dfw_pkg::CLK_BITS-1:0]  i_cfg_wr_data
);
    import dfw_pkg::*;

    logic [CLK_BITS-1:0] r_clk_hz;
    logic                r_s1_valid;
    t_div_req            r_s1;
    t_div_req            n_s1;

    logic                in_acc;
    logic                div_ready;
    logic                div_valid;
    t_job                div_job;
    logic                ser_take;

    // Master clock register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= CLK_HZ_RESET;
        end else if (i_cfg_wr_en) begin
            r_clk_hz <= i_cfg_wr_data;
        end
    end

    // Stage one: decode and form the numerator f * 2^28 + clk * 128.
    assign o_in_stall = r_s1_valid && !div_ready;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1.kind = i_in.req_type;
        n_s1.neg  = (i_in.req_type == REQ_HZ) && i_in.freq_q8[FREQ_BITS-1];
        n_s1.raw  = i_in.tuning_word;
        n_s1.num  = {1'b0, i_in.freq_q8[FREQ_BITS-2:0], {WORD_BITS{1'b0}}}
                  + {{(NUM_BITS-CLK_BITS-7){1'b0}}, r_clk_hz, 7'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= (i_in.req_type != REQ_NONE);
        end else if (div_ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
    end

    // Stage two: tuning word division.
    dfw_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid),
        .o_ready  (div_ready),
        .i_req    (r_s1),
        .i_clk_hz (r_clk_hz),
        .o_valid  (div_valid),
        .o_job    (div_job),
        .i_take   (ser_take)
    );

    // Stage three: frame serializer and output register.
    dfw_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (div_valid),
        .o_take      (ser_take),
        .i_job       (div_job),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    // The final bit of a run is always the end of a frame.
    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.last) |-> o_out.frame_end)
        else $error("last bit without frame end");

    // An accepted request of a known type enters stage one.
    a_req_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.req_type != REQ_NONE)) |=> r_s1_valid)
        else $error("accepted request lost at stage one");

    // Reset empties the output.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule
`default_nettype wire
